### rtl/core/nway_elementwise_median_macros.svh
// Assertion helpers for the element-wise median core.
// All of them sample on clk and stay quiet while rst_n is low.
`ifndef NWAY_ELEMENTWISE_MEDIAN_MACROS_SVH
`define NWAY_ELEMENTWISE_MEDIAN_MACROS_SVH

`ifndef SYNTHESIS
`define NEM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("nem check failed");
`define NEM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nem check failed");
`define NEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nem check failed");
`else
`define NEM_ASSERT_ALWAYS(label, expr)
`define NEM_ASSERT_IMPLY(label, ante, cons)
`define NEM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/nem_pkg.sv
package nem_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int FIELD_SLOTS      = 8;
    localparam int MAX_INPUTS_DEF   = 8;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_INPUTS_IN_USE  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_SAMPLES = CFG_INDEX_W'(1);

    // what one lane found for its candidate
    typedef struct packed {
        logic                   hit;
        logic [SAMPLE_BITS-1:0] value;
    } lane_res_t;

endpackage

### rtl/core/nem_sample_if.sv
interface nem_sample_if;
    logic                              valid;
    logic                              ready;
    logic [nem_pkg::SAMPLE_BITS-1:0]   sample_0;
    logic [nem_pkg::SAMPLE_BITS-1:0]   sample_1;
    logic [nem_pkg::SAMPLE_BITS-1:0]   sample_2;
    logic [nem_pkg::SAMPLE_BITS-1:0]   sample_3;
    logic [nem_pkg::SAMPLE_BITS-1:0]   sample_4;
    logic [nem_pkg::SAMPLE_BITS-1:0]   sample_5;
    logic [nem_pkg::SAMPLE_BITS-1:0]   sample_6;
    logic [nem_pkg::SAMPLE_BITS-1:0]   sample_7;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        input  ready
    );

    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        output ready
    );
endinterface

### rtl/core/nem_median_if.sv
interface nem_median_if;
    logic                              valid;
    logic                              ready;
    logic [nem_pkg::SAMPLE_BITS-1:0]   median_value;

    modport source (
        output valid, median_value,
        input  ready
    );

    modport sink (
        input  valid, median_value,
        output ready
    );
endinterface

### rtl/core/nem_lane.sv
module nem_lane #(
    parameter int MAX_INPUTS = nem_pkg::MAX_INPUTS_DEF,
    parameter int KEY_W      = nem_pkg::SAMPLE_BITS,
    parameter int N_W        = 4,
    parameter int RANK_W     = 3,
    parameter int LANE       = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [KEY_W-1:0]           keys [MAX_INPUTS],
    input  logic [KEY_W-1:0]           value,
    input  logic [N_W-1:0]             n,
    input  logic [RANK_W-1:0]          target,
    output nem_pkg::lane_res_t         res
);

    logic [RANK_W-1:0]  rank;
    logic               hit;
    nem_pkg::lane_res_t res_reg;

    // stable rank: smaller keys, plus equal keys at a lower field index
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < MAX_INPUTS; j++)
        begin
            if ((N_W'(j) < n) &&
                ((keys[j] < keys[LANE]) || ((keys[j] == keys[LANE]) && (j < LANE))))
            begin
                rank = rank + RANK_W'(1);
            end
        end
        hit = (N_W'(LANE) < n) && (rank == target);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.hit   <= hit;
            res_reg.value <= nem_pkg::SAMPLE_BITS'(value);
        end
    end

    assign res = res_reg;

endmodule

### rtl/core/nem_merge.sv
module nem_merge #(
    parameter int MAX_INPUTS = nem_pkg::MAX_INPUTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nem_pkg::lane_res_t    lanes [MAX_INPUTS],
    input  logic                  lanes_valid,
    output logic                  free,
    nem_median_if.source          result
);

    logic [nem_pkg::SAMPLE_BITS-1:0] pick;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [nem_pkg::SAMPLE_BITS-1:0] out_value_reg;

    // exactly one lane hits, so an OR of the gated values selects it
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < MAX_INPUTS; i++)
        begin
            if (lanes[i].hit)
            begin
                pick = pick | lanes[i].value;
            end
        end
    end

    assign free           = !out_valid_reg || result.ready;
    assign out_valid_next = free ? lanes_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && lanes_valid)
        begin
            out_value_reg <= pick;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.median_value = out_value_reg;

endmodule

### rtl/core/nway_elementwise_median.sv
// Channel   Role    Payload
// samples   sink    sample_0 .. sample_7, 16 bits each
// result    source  median_value, 16 bits
// cfg_*     write   cfg_index selects the register, cfg_data carries the value
//
// One transfer per cycle sustained while result.ready holds; two register stages, so an
// input passes the lane registers and then the output register before its result transfers.
// Stage one: MAX_INPUTS rank lanes compare their candidate against the samples in use
// and register a hit flag. Stage two: the merge stage selects the hit into the
// output register. Each stage moves when the next one is empty or draining, so
// a stalled result never blocks a bubble from filling. Reset clears the valid
// flags and loads count 1, unsigned compare.
`include "nway_elementwise_median_macros.svh"

module nway_elementwise_median #(
    parameter int MAX_INPUTS   = nem_pkg::MAX_INPUTS_DEF,
    parameter int SAMPLE_WIDTH = nem_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    nem_sample_if.sink                         samples,
    nem_median_if.source                       result,
    input  logic                               cfg_we,
    input  logic [nem_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nem_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int KEY_W = (SAMPLE_WIDTH < nem_pkg::SAMPLE_BITS) ?
                           SAMPLE_WIDTH : nem_pkg::SAMPLE_BITS;
    // above the field width the masked sign bit is always clear
    localparam bit SIGN_IN_KEY = (SAMPLE_WIDTH <= nem_pkg::SAMPLE_BITS);
    localparam int N_W    = $clog2(MAX_INPUTS + 1);
    localparam int RANK_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam logic [KEY_W-1:0] MSB_MASK = KEY_W'(1) << (KEY_W - 1);

    // configuration
    logic [N_W-1:0]                   n_reg;
    logic [N_W-1:0]                   n_next;
    logic [RANK_W-1:0]                target_reg;
    logic [RANK_W-1:0]                target_next;
    logic                             signed_reg;
    logic                             signed_next;
    logic [N_W-1:0]                   n_cfg;

    // datapath
    logic [nem_pkg::SAMPLE_BITS-1:0]  raw    [nem_pkg::FIELD_SLOTS];
    logic [KEY_W-1:0]                 masked [MAX_INPUTS];
    logic [KEY_W-1:0]                 keys   [MAX_INPUTS];
    nem_pkg::lane_res_t               lanes  [MAX_INPUTS];
    logic [MAX_INPUTS-1:0]            hits;
    logic                             flip;

    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic                             s1_free;
    logic                             merge_free;
    logic                             accept;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            n_cfg = N_W'(1);
        end
        else if (cfg_data > nem_pkg::CFG_DATA_W'(MAX_INPUTS))
        begin
            n_cfg = N_W'(MAX_INPUTS);
        end
        else
        begin
            n_cfg = N_W'(cfg_data);
        end

        n_next      = n_reg;
        target_next = target_reg;
        signed_next = signed_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                nem_pkg::CFG_INPUTS_IN_USE:
                begin
                    n_next      = n_cfg;
                    target_next = RANK_W'(n_cfg >> 1);
                end
                nem_pkg::CFG_SIGNED_SAMPLES:
                begin
                    signed_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= N_W'(1);
            target_reg <= '0;
            signed_reg <= 1'b0;
        end
        else
        begin
            n_reg      <= n_next;
            target_reg <= target_next;
            signed_reg <= signed_next;
        end
    end

    assign raw[0] = samples.sample_0;
    assign raw[1] = samples.sample_1;
    assign raw[2] = samples.sample_2;
    assign raw[3] = samples.sample_3;
    assign raw[4] = samples.sample_4;
    assign raw[5] = samples.sample_5;
    assign raw[6] = samples.sample_6;
    assign raw[7] = samples.sample_7;

    assign flip = signed_reg && SIGN_IN_KEY;

    // signed order becomes unsigned order once the sign bit is inverted
    always_comb
    begin
        for (int i = 0; i < MAX_INPUTS; i++)
        begin
            masked[i] = raw[i][KEY_W-1:0];
            keys[i]   = masked[i] ^ (flip ? MSB_MASK : '0);
        end
    end

    assign s1_free       = !s1_valid_reg || merge_free;
    assign accept        = samples.valid && s1_free;
    assign s1_valid_next = s1_free ? samples.valid : s1_valid_reg;
    assign samples.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    for (genvar g = 0; g < MAX_INPUTS; g++)
    begin : g_lane
        nem_lane #(
            .MAX_INPUTS (MAX_INPUTS),
            .KEY_W      (KEY_W),
            .N_W        (N_W),
            .RANK_W     (RANK_W),
            .LANE       (g)
        ) u_lane (
            .clk    (clk),
            .en     (accept),
            .keys   (keys),
            .value  (masked[g]),
            .n      (n_reg),
            .target (target_reg),
            .res    (lanes[g])
        );
        assign hits[g] = lanes[g].hit;
    end

    nem_merge #(
        .MAX_INPUTS (MAX_INPUTS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lanes       (lanes),
        .lanes_valid (s1_valid_reg),
        .free        (merge_free),
        .result      (result)
    );

    // ranks form a permutation of 0..n-1, so exactly one lane holds the target
    `NEM_ASSERT_IMPLY(a_one_lane_hit, s1_valid_reg, $onehot(hits))
    `NEM_ASSERT_ALWAYS(a_count_range, (n_reg != '0) && (n_reg <= N_W'(MAX_INPUTS)))
    `NEM_ASSERT_ALWAYS(a_target_half, target_reg == RANK_W'(n_reg >> 1))
    `NEM_ASSERT_NEXT(a_accept_fills, accept, s1_valid_reg)

endmodule

### dv/tb_nway_elementwise_median.sv
module tb_nway_elementwise_median;
    import nem_pkg::*;

    localparam int RESULT_LATENCY   = 2;
    localparam int RESET_CYCLES     = 7;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int MISMATCH_REPORTS = 10;
    localparam int HOLD_CYCLES      = 300;

    // indexes with no register behind them; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = CFG_INDEX_W'(3);

    // index 0 on the left, so literals read in field order
    typedef logic [0:FIELD_SLOTS-1][SAMPLE_BITS-1:0] sample_set_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    nem_sample_if sample_ch ();
    nem_median_if median_ch ();

    nway_elementwise_median dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .result    (median_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [SAMPLE_BITS-1:0] expected_medians [$];
    logic [CFG_DATA_W-1:0]  shadow_count;
    logic                   shadow_signed;
    int                     fail_count        = 0;
    int                     sender_idle_pct   = 0;
    int                     receiver_idle_pct = 0;
    int                     hold_request      = 0;
    int                     hold_left         = 0;

    always #2 clk = ~clk;

    function automatic logic [SAMPLE_BITS-1:0] predict_median(input sample_set_t s,
                                                             input logic [CFG_DATA_W-1:0] count,
                                                             input logic as_signed);
        logic [SAMPLE_BITS-1:0] keys [FIELD_SLOTS];
        logic [SAMPLE_BITS-1:0] pick;
        int n;
        int rank;
        n = int'(count);
        if (n < 1) n = 1;
        if (n > MAX_INPUTS_DEF) n = MAX_INPUTS_DEF;
        // flipping the sign bit turns two's complement order into unsigned order
        for (int i = 0; i < n; i++)
            keys[i] = s[i] ^ {as_signed, {(SAMPLE_BITS-1){1'b0}}};
        pick = '0;
        for (int i = 0; i < n; i++)
        begin
            rank = 0;
            for (int j = 0; j < n; j++)
                if (keys[j] < keys[i] || (keys[j] == keys[i] && j < i))
                    rank++;
            if (rank == n / 2)
                pick = s[i];
        end
        return pick;
    endfunction

    function automatic sample_set_t random_samples();
        sample_set_t s;
        logic [SAMPLE_BITS-1:0] pool [4];
        int mode;
        mode = $urandom_range(9);
        for (int p = 0; p < 4; p++)
            pool[p] = SAMPLE_BITS'($urandom);
        for (int i = 0; i < FIELD_SLOTS; i++)
        begin
            case (mode)
                6, 7:    s[i] = pool[$urandom_range(3)];    // heavy duplicates
                8:       s[i] = $urandom_range(1) ? {SAMPLE_BITS{1'b1}} - SAMPLE_BITS'($urandom_range(1))
                                                  : {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                                    - SAMPLE_BITS'($urandom_range(1));
                9:       s[i] = SAMPLE_BITS'($urandom_range(6)) - SAMPLE_BITS'(3);  // around zero
                default: s[i] = SAMPLE_BITS'($urandom);
            endcase
        end
        return s;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MISMATCH_REPORTS)
            $display("%s", msg);
    endtask

    task automatic send_samples(input sample_set_t s);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.sample_0 <= s[0];
        sample_ch.sample_1 <= s[1];
        sample_ch.sample_2 <= s[2];
        sample_ch.sample_3 <= s[3];
        sample_ch.sample_4 <= s[4];
        sample_ch.sample_5 <= s[5];
        sample_ch.sample_6 <= s[6];
        sample_ch.sample_7 <= s[7];
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        // transfer taken at this edge; valid stays up until the next call decides
        expected_medians = {expected_medians,
                            predict_median(s, shadow_count, shadow_signed)};
    endtask

    task automatic wait_for_results();
        int waited;
        waited = 0;
        sample_ch.valid <= 1'b0;
        while (expected_medians.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (RESULT_LATENCY + 2) @(posedge clk);
        while (expected_medians.size() != 0)
            note_failure($sformatf("missing result, expected median_value %h",
                                   expected_medians.pop_front()));
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_INPUTS_IN_USE:  shadow_count  = data;
            CFG_SIGNED_SAMPLES: shadow_signed = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] count,
                              input logic [CFG_DATA_W-1:0] signed_data);
        wait_for_results();
        write_register(CFG_INPUTS_IN_USE, count);
        write_register(CFG_SIGNED_SAMPLES, signed_data);
    endtask

    task automatic apply_reset();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.sample_0 = '0;
        sample_ch.sample_1 = '0;
        sample_ch.sample_2 = '0;
        sample_ch.sample_3 = '0;
        sample_ch.sample_4 = '0;
        sample_ch.sample_5 = '0;
        sample_ch.sample_6 = '0;
        sample_ch.sample_7 = '0;
        median_ch.ready    = 1'b0;
        shadow_count       = CFG_DATA_W'(1);
        shadow_signed      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    endtask

    task automatic test_directed_extremes();
        sample_set_t mixed;
        mixed = {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h8001, 16'h7FFE};
        // reset setting: one input, unsigned
        send_samples({8{16'h0000}});
        send_samples({8{16'hFFFF}});
        send_samples({16'h1234, {7{16'hFFFF}}});
        // zero count behaves as one
        set_config(4'd0, 4'd0);
        send_samples({16'hABCD, {7{16'h0000}}});
        set_config(4'd8, 4'd0);
        send_samples(mixed);
        send_samples({16'd5, 16'd5, 16'd5, 16'd1, 16'd9, 16'd9, 16'd5, 16'd5});
        send_samples({16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7});
        send_samples({16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0});
        set_config(4'd8, 4'd1);
        send_samples(mixed);
        send_samples({{4{16'h8000}}, {4{16'h7FFF}}});
        send_samples({8{16'h8000}});
        // even count takes the upper of the middle pair
        set_config(4'd2, 4'd0);
        send_samples({16'd3, 16'd7, {6{16'h0000}}});
        set_config(4'd2, 4'd1);
        send_samples({16'hFFFF, 16'h0001, {6{16'h8000}}});
        // counts above capacity clamp to all eight; then seven inputs, signed
        set_config(4'd15, 4'd1);
        send_samples(mixed);
        set_config(4'd9, 4'd0);
        send_samples(mixed);
        set_config(4'd7, 4'd1);
        send_samples(mixed);
        send_samples({16'hFFFF, 16'hFFFE, 16'h0000, 16'h8000, 16'h0002, 16'h7FFF, 16'h0001, 16'h1111});
    endtask

    task automatic test_register_decode();
        sample_set_t mixed;
        mixed = {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h8001, 16'h7FFE};
        set_config(4'd3, 4'd0);
        write_register(CFG_UNMAPPED_LO, 4'hF);
        write_register(CFG_UNMAPPED_HI, 4'hF);
        send_samples(mixed);
        // only bit 0 of the data selects signed compare
        wait_for_results();
        write_register(CFG_SIGNED_SAMPLES, 4'b1110);
        send_samples(mixed);
        wait_for_results();
        write_register(CFG_SIGNED_SAMPLES, 4'b0011);
        send_samples(mixed);
        wait_for_results();
        write_register(CFG_UNMAPPED_HI, 4'h0);
        send_samples(mixed);
    endtask

    task automatic test_random_sweep(input int item_count, input int send_pct, input int recv_pct);
        logic [CFG_DATA_W-1:0] count;
        int sent;
        int burst;
        sent = 0;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        while (sent < item_count)
        begin
            case ($urandom_range(9))
                0:       count = 4'd0;
                1:       count = CFG_DATA_W'($urandom_range(15, 9));
                default: count = CFG_DATA_W'($urandom_range(8, 1));
            endcase
            set_config(count, CFG_DATA_W'($urandom_range(15)));
            burst = $urandom_range(60, 20);
            for (int k = 0; k < burst && sent < item_count; k++)
            begin
                send_samples(random_samples());
                sent++;
            end
        end
        wait_for_results();
    endtask

    task automatic test_result_backpressure();
        set_config(4'd8, 4'd1);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_request      = HOLD_CYCLES;
        // results are held back, so the pipeline fills and input ready drops
        for (int k = 0; k < 40; k++)
            send_samples(random_samples());
        wait_for_results();
    endtask

    task automatic test_sender_pause();
        set_config(4'd5, 4'd0);
        sender_idle_pct   = 20;
        receiver_idle_pct = 30;
        for (int k = 0; k < 15; k++)
            send_samples(random_samples());
        // nothing new goes in until every result is back
        wait_for_results();
        for (int k = 0; k < 15; k++)
            send_samples(random_samples());
        wait_for_results();
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            median_ch.ready <= 1'b0;
        end
        else
            median_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && median_ch.valid && median_ch.ready)
        begin
            if (expected_medians.size() == 0)
                note_failure($sformatf("unexpected result, median_value %h",
                                       median_ch.median_value));
            else if (median_ch.median_value !== expected_medians[0])
                note_failure($sformatf("median_value mismatch: expected %h, got %h",
                                       expected_medians.pop_front(), median_ch.median_value));
            else
                void'(expected_medians.pop_front());
        end
    end

    initial
    begin
        apply_reset();
        test_directed_extremes();
        test_register_decode();
        test_random_sweep(250, 9, 65);
        test_random_sweep(250, 65, 9);
        test_random_sweep(250, 0, 0);
        test_result_backpressure();
        test_sender_pause();
        wait_for_results();
        if (fail_count == 0)
            $display("nway_elementwise_median regression: pass");
        else
            $display("nway_elementwise_median regression: fail");
        $finish;
    end

    initial
    begin
        #800000;
        $display("nway_elementwise_median regression: fail");
        $finish;
    end

endmodule
